// File: hdl/bcvs_pkg.sv
// Shared types and constants for the battery charge voltage step block.
// Used by the divider, datapath, controller and top level by scoped names.
package bcvs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SUM_W     = 40;
   localparam int DIV_W     = SUM_W + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONSTANT_COEF  = 3'd0,
      CSR_LINEAR_COEF    = 3'd1,
      CSR_CAPACITY       = 3'd2,
      CSR_INITIAL_CHARGE = 3'd3,
      CSR_SMOOTHING_GAIN = 3'd4,
      CSR_STEP_HOURS     = 3'd5,
      CSR_RESISTANCE     = 3'd6,
      CSR_ALLOW_CHARGING = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_FULL        = 2'd0,
      STATUS_DISCHARGING = 2'd1,
      STATUS_CHARGING    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      CTL_IDLE,
      CTL_DIV_I_GO,
      CTL_DIV_I_WAIT,
      CTL_SMOOTH,
      CTL_SC,
      CTL_MULQ,
      CTL_Q,
      CTL_DIV_R_GO,
      CTL_DIV_R_WAIT,
      CTL_MUL_V,
      CTL_FIN
   } ctl_state_type;

   typedef struct packed {
      logic acc_en;
      logic div_start;
      logic div_sel_ratio;
      logic ld_iraw;
      logic ld_m1;
      logic ld_sc;
      logic ld_m2;
      logic ld_q;
      logic ld_ratio;
      logic ld_m3;
      logic ld_fin;
   } ctl_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

// File: hdl/battery_charge_voltage_step.sv
// Top level of the battery charge voltage step block.
// Depends on bcvs_pkg, bcvs_ctrl and bcvs_datapath.
//
// channel  ports                                       direction
// req      req_valid/req_stall, load_power, last_load  in
// rsp      rsp_valid/rsp_stall, six result fields      out
// csr      csr_write, csr_index, csr_wdata             in
//
// A load that is not last is accumulated and the controller stays idle. A last
// load runs the step: two divisions on the shared restoring divider plus the
// sequencing states, with req_stall high until the step is back in idle. Reset
// is synchronous and loads the register defaults. The result waits in an output
// register; rsp_stall holds the step in its final state only while a word is
// pending.
module battery_charge_voltage_step (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [31:0]             req_load_power,
   input  logic                           req_last_load,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_terminal_voltage,
   output logic signed [31:0]             rsp_current,
   output logic [30:0]                    rsp_charge,
   output logic [1:0]                     rsp_supply_status,
   output logic [30:0]                    rsp_charge_total,
   output logic [30:0]                    rsp_discharge_total,
   input  logic                           csr_write,
   input  logic [bcvs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcvs_pkg::CSR_DAT_W-1:0] csr_wdata
);

   bcvs_pkg::ctl_cmd_type   cmd;
   bcvs_pkg::dp_status_type status;

   bcvs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_load (req_last_load),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   bcvs_datapath u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_load_power       (req_load_power),
      .cmd                  (cmd),
      .status               (status),
      .rsp_terminal_voltage (rsp_terminal_voltage),
      .rsp_current          (rsp_current),
      .rsp_charge           (rsp_charge),
      .rsp_supply_status    (rsp_supply_status),
      .rsp_charge_total     (rsp_charge_total),
      .rsp_discharge_total  (rsp_discharge_total)
   );

endmodule

// File: hdl/bcvs_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on bcvs_pkg for the dividend width.
module bcvs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bcvs_pkg::DIV_W-1:0] dividend,
   input  logic [31:0]                divisor,
   output logic                       done,
   output logic [bcvs_pkg::DIV_W-1:0] quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [bcvs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]                    rem_ff, rem_in;
   logic [bcvs_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [31:0]                    dsr_ff, dsr_in;
   logic [32:0]                    rem_t;
   logic [32:0]                    rem_d;
   logic                           ge;

   always_comb begin
      rem_t = {rem_ff, quo_ff[bcvs_pkg::DIV_W-1]};
      ge    = rem_t >= {1'b0, dsr_ff};
      rem_d = rem_t - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_d[31:0] : rem_t[31:0];
         quo_in = {quo_ff[bcvs_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bcvs_pkg::DIV_CNT_W'(bcvs_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/bcvs_datapath.sv
// Datapath: configuration registers, power sums, battery state and step math.
// Depends on bcvs_pkg and instantiates bcvs_div.
module bcvs_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [bcvs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcvs_pkg::CSR_DAT_W-1:0] csr_wdata,
   input  logic signed [31:0]            req_load_power,
   input  bcvs_pkg::ctl_cmd_type         cmd,
   output bcvs_pkg::dp_status_type       status,
   output logic signed [31:0]            rsp_terminal_voltage,
   output logic signed [31:0]            rsp_current,
   output logic [30:0]                   rsp_charge,
   output logic [1:0]                    rsp_supply_status,
   output logic [30:0]                   rsp_charge_total,
   output logic [30:0]                   rsp_discharge_total
);

   localparam int F = bcvs_pkg::FRAC_BITS;
   localparam int SW = bcvs_pkg::SUM_W;

   function automatic logic signed [65:0] fx(input logic signed [65:0] p);
      logic signed [65:0] r;
      r = p;
      if (p < 0) r = p + 66'sd1 * ((66'sd1 <<< F) - 66'sd1);
      return r >>> F;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      r = x[31:0];
      if (x[65] && (&x[64:31]) == 1'b0) r = {1'b1, 31'd0};
      else if (!x[65] && (|x[64:31])) r = {1'b0, {31{1'b1}}};
      return r;
   endfunction

   function automatic logic [30:0] satu31(input logic signed [65:0] x);
      logic [30:0] r;
      r = x[30:0];
      if (x < 0) r = '0;
      else if (|x[64:31]) r = '1;
      return r;
   endfunction

   function automatic logic signed [SW-1:0] sat40(input logic signed [SW:0] x);
      logic signed [SW-1:0] r;
      r = x[SW-1:0];
      if (x[SW] != x[SW-1]) r = x[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      return r;
   endfunction

   logic signed [31:0] cc_ff, lc_ff;
   logic [30:0]        cap_ff, res_ff;
   logic [16:0]        gain_ff, step_ff;
   logic               allow_ff;

   logic signed [SW-1:0] net_ff, net_in, dis_ff, dis_in, chg_ff, chg_in;
   logic signed [31:0]   sc_ff, sc_in, prev_ff, prev_in;
   logic [30:0]          stored_ff, stored_in;

   logic signed [31:0]   iraw_ff, iraw_in;
   logic signed [50:0]   m1_ff;
   logic signed [49:0]   m2a_ff;
   logic signed [63:0]   m2b_ff;
   logic [30:0]          qn_ff, qn_in;
   logic [30:0]          ratio_ff, ratio_in;
   logic signed [64:0]   m3_ff;

   logic signed [31:0]   o_et_ff, o_sc_ff;
   logic [30:0]          o_q_ff, o_cp_ff, o_dp_ff;
   logic [1:0]           o_st_ff;

   logic signed [32:0]   vsum, vmax;
   logic                 v_pos, net_neg;
   logic [SW-1:0]        net_abs;
   logic [bcvs_pkg::DIV_W-1:0] div_dividend, quot;
   logic [31:0]          div_divisor;
   logic [30:0]          cap_eff;
   logic                 div_done;
   logic signed [32:0]   d_cur, omr;
   logic signed [65:0]   sc_sum, q_sum, et_w;
   logic signed [31:0]   et_cap, et_fin, sc_fin;
   logic [30:0]          q_fin, cp_fin, dp_fin;
   logic [1:0]           st_fin;
   logic signed [SW-1:0] cpow, dpow;
   logic signed [SW:0]   net_add, dis_add, chg_add;

   bcvs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quot)
   );

   assign status.div_done = div_done;

   always_comb begin
      vsum    = 33'(cc_ff) + 33'(lc_ff);
      vmax    = (33'(prev_ff) > vsum) ? 33'(prev_ff) : vsum;
      v_pos   = vmax > 0;
      net_neg = net_ff[SW-1];
      net_abs = net_neg ? (~net_ff + 1'b1) : net_ff;
      cap_eff = (cap_ff == '0) ? 31'd1 : cap_ff;
      if (cmd.div_sel_ratio) begin
         div_dividend = bcvs_pkg::DIV_W'(qn_ff) << F;
         div_divisor  = {1'b0, cap_eff};
      end else begin
         div_dividend = bcvs_pkg::DIV_W'(net_abs) << F;
         div_divisor  = vmax[31:0];
      end

      net_add = (SW+1)'(net_ff) + (SW+1)'(req_load_power);
      dis_add = (SW+1)'(dis_ff) + (SW+1)'(req_load_power);
      chg_add = (SW+1)'(chg_ff) - (SW+1)'(req_load_power);
      net_in = net_ff;
      dis_in = dis_ff;
      chg_in = chg_ff;
      if (cmd.acc_en) begin
         if (!req_load_power[31] || allow_ff) net_in = sat40(net_add);
         if (!req_load_power[31]) dis_in = sat40(dis_add);
         if (allow_ff && req_load_power[31]) chg_in = sat40(chg_add);
      end else if (cmd.ld_fin) begin
         net_in = '0;
         dis_in = '0;
         chg_in = '0;
      end

      if (!v_pos) iraw_in = '0;
      else if (net_neg) iraw_in = sat32(-$signed({10'd0, quot}));
      else iraw_in = sat32($signed({10'd0, quot}));

      d_cur  = 33'(iraw_ff) - 33'(sc_ff);
      sc_sum = 66'(sc_ff) + fx(66'(m1_ff));
      q_sum  = $signed({35'd0, stored_ff}) - fx(66'(m2a_ff));
      qn_in  = satu31(q_sum);
      ratio_in = (|quot[bcvs_pkg::DIV_W-1:31]) ? '1 : quot[30:0];
      omr    = (33'sd1 <<< F) - $signed({2'b00, ratio_ff});

      et_w   = 66'(cc_ff) + fx(66'(m3_ff)) - fx(66'(m2b_ff));
      et_cap = (et_w > 66'(cc_ff)) ? cc_ff : sat32(et_w);
      et_fin = et_cap;
      sc_fin = sc_ff;
      q_fin  = qn_ff;
      cpow   = chg_ff;
      dpow   = dis_ff;
      if (qn_ff == '0) begin
         et_fin = '0;
         if (dpow > cpow) dpow = cpow;
      end else if (qn_ff >= cap_eff) begin
         q_fin = cap_eff;
         if (sc_ff < 0) sc_fin = '0;
         cpow = '0;
      end
      if (q_fin == cap_eff) st_fin = bcvs_pkg::STATUS_FULL;
      else if (!sc_fin[31]) st_fin = bcvs_pkg::STATUS_DISCHARGING;
      else st_fin = bcvs_pkg::STATUS_CHARGING;
      cp_fin = satu31(66'(cpow));
      dp_fin = satu31(66'(dpow));

      sc_in = sc_ff;
      if (cmd.ld_sc) sc_in = sat32(sc_sum);
      else if (cmd.ld_fin) sc_in = sc_fin;
      stored_in = stored_ff;
      prev_in   = prev_ff;
      if (cmd.ld_fin) begin
         stored_in = q_fin;
         prev_in   = et_fin;
      end
      if (csr_write && csr_index == bcvs_pkg::CSR_INITIAL_CHARGE) stored_in = csr_wdata[30:0];
      if (csr_write && csr_index == bcvs_pkg::CSR_CONSTANT_COEF) prev_in = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff     <= '0;
         lc_ff     <= '0;
         cap_ff    <= 31'(1 << F);
         gain_ff   <= 17'(1 << F);
         step_ff   <= '0;
         res_ff    <= '0;
         allow_ff  <= 1'b0;
         net_ff    <= '0;
         dis_ff    <= '0;
         chg_ff    <= '0;
         sc_ff     <= '0;
         stored_ff <= 31'(1 << F);
         prev_ff   <= '0;
      end else begin
         net_ff    <= net_in;
         dis_ff    <= dis_in;
         chg_ff    <= chg_in;
         sc_ff     <= sc_in;
         stored_ff <= stored_in;
         prev_ff   <= prev_in;
         if (csr_write) begin
            unique case (bcvs_pkg::csr_index_type'(csr_index))
               bcvs_pkg::CSR_CONSTANT_COEF:  cc_ff    <= csr_wdata;
               bcvs_pkg::CSR_LINEAR_COEF:    lc_ff    <= csr_wdata;
               bcvs_pkg::CSR_CAPACITY:       cap_ff   <= csr_wdata[30:0];
               bcvs_pkg::CSR_INITIAL_CHARGE: ;
               bcvs_pkg::CSR_SMOOTHING_GAIN: gain_ff  <= csr_wdata[16:0];
               bcvs_pkg::CSR_STEP_HOURS:     step_ff  <= csr_wdata[16:0];
               bcvs_pkg::CSR_RESISTANCE:     res_ff   <= csr_wdata[30:0];
               bcvs_pkg::CSR_ALLOW_CHARGING: allow_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      if (cmd.ld_iraw)  iraw_ff  <= iraw_in;
      if (cmd.ld_m1)    m1_ff    <= $signed({1'b0, gain_ff}) * d_cur;
      if (cmd.ld_m2) begin
         m2a_ff <= $signed({1'b0, step_ff}) * sc_ff;
         m2b_ff <= $signed({1'b0, res_ff}) * sc_ff;
      end
      if (cmd.ld_q)     qn_ff    <= qn_in;
      if (cmd.ld_ratio) ratio_ff <= ratio_in;
      if (cmd.ld_m3)    m3_ff    <= lc_ff * omr;
      if (cmd.ld_fin) begin
         o_et_ff <= et_fin;
         o_sc_ff <= sc_fin;
         o_q_ff  <= q_fin;
         o_st_ff <= st_fin;
         o_cp_ff <= cp_fin;
         o_dp_ff <= dp_fin;
      end
   end

   assign rsp_terminal_voltage = o_et_ff;
   assign rsp_current          = o_sc_ff;
   assign rsp_charge           = o_q_ff;
   assign rsp_supply_status    = o_st_ff;
   assign rsp_charge_total     = o_cp_ff;
   assign rsp_discharge_total  = o_dp_ff;

endmodule

// File: hdl/bcvs_ctrl.sv
// Controller: sequences accumulate, two divisions and the step, owns handshakes.
// Depends on bcvs_pkg.
module bcvs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last_load,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  bcvs_pkg::dp_status_type status,
   output bcvs_pkg::ctl_cmd_type   cmd
);

   bcvs_pkg::ctl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && (state_ff == bcvs_pkg::CTL_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcvs_pkg::CTL_IDLE:       if (accept && req_last_load) state_in = bcvs_pkg::CTL_DIV_I_GO;
         bcvs_pkg::CTL_DIV_I_GO:   state_in = bcvs_pkg::CTL_DIV_I_WAIT;
         bcvs_pkg::CTL_DIV_I_WAIT: if (status.div_done) state_in = bcvs_pkg::CTL_SMOOTH;
         bcvs_pkg::CTL_SMOOTH:     state_in = bcvs_pkg::CTL_SC;
         bcvs_pkg::CTL_SC:         state_in = bcvs_pkg::CTL_MULQ;
         bcvs_pkg::CTL_MULQ:       state_in = bcvs_pkg::CTL_Q;
         bcvs_pkg::CTL_Q:          state_in = bcvs_pkg::CTL_DIV_R_GO;
         bcvs_pkg::CTL_DIV_R_GO:   state_in = bcvs_pkg::CTL_DIV_R_WAIT;
         bcvs_pkg::CTL_DIV_R_WAIT: if (status.div_done) state_in = bcvs_pkg::CTL_MUL_V;
         bcvs_pkg::CTL_MUL_V:      state_in = bcvs_pkg::CTL_FIN;
         bcvs_pkg::CTL_FIN:        if (out_free) state_in = bcvs_pkg::CTL_IDLE;
         default:                  state_in = bcvs_pkg::CTL_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         bcvs_pkg::CTL_IDLE: begin
            req_stall  = 1'b0;
            cmd.acc_en = req_valid;
         end
         bcvs_pkg::CTL_DIV_I_GO:   cmd.div_start = 1'b1;
         bcvs_pkg::CTL_DIV_I_WAIT: cmd.ld_iraw = status.div_done;
         bcvs_pkg::CTL_SMOOTH:     cmd.ld_m1 = 1'b1;
         bcvs_pkg::CTL_SC:         cmd.ld_sc = 1'b1;
         bcvs_pkg::CTL_MULQ:       cmd.ld_m2 = 1'b1;
         bcvs_pkg::CTL_Q:          cmd.ld_q = 1'b1;
         bcvs_pkg::CTL_DIV_R_GO: begin
            cmd.div_start     = 1'b1;
            cmd.div_sel_ratio = 1'b1;
         end
         bcvs_pkg::CTL_DIV_R_WAIT: begin
            cmd.div_sel_ratio = 1'b1;
            cmd.ld_ratio      = status.div_done;
         end
         bcvs_pkg::CTL_MUL_V:      cmd.ld_m3 = 1'b1;
         bcvs_pkg::CTL_FIN:        cmd.ld_fin = out_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.ld_fin || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcvs_pkg::CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_fin_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_fin |-> (!rsp_valid_ff || !rsp_stall)) else $error("result overwrite");
   a_div_to_smooth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcvs_pkg::CTL_DIV_I_WAIT && status.div_done) |=>
      state_ff == bcvs_pkg::CTL_SMOOTH) else $error("bad sequence after divide");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bcvs_pkg::CTL_IDLE) |-> !cmd.acc_en) else $error("accumulate while busy");
   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_fin |=> rsp_valid_ff) else $error("result not presented");

endmodule

// File: bench/testbench.sv
// Self-checking bench for battery_charge_voltage_step: predicts each tick result
// in fixed point and compares every rsp word field by field. Depends on bcvs_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint S40_MAX = 64'sd549755813887;
   localparam longint S40_MIN = -S40_MAX - 1;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -S32_MAX - 1;
   localparam longint U31_MAX = 64'sd2147483647;
   localparam longint ONE     = 64'sd65536;
   localparam int     LIMIT   = 4000000;

   typedef struct {
      logic signed [31:0]   voltage;
      logic signed [31:0]   current;
      logic [30:0]          charge;
      bcvs_pkg::status_type status;
      logic [30:0]          chg_pwr;
      logic [30:0]          dis_pwr;
   } tick_word_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_last_load = 0, rsp_stall = 0;
   logic signed [31:0] req_load_power = 0;
   logic req_stall, rsp_valid;
   logic signed [31:0] rsp_terminal_voltage, rsp_current;
   logic [30:0] rsp_charge, rsp_charge_total, rsp_discharge_total;
   logic [1:0] rsp_supply_status;
   logic csr_write = 0;
   logic [bcvs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bcvs_pkg::CSR_DAT_W-1:0] csr_wdata = '0;

   battery_charge_voltage_step u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   longint k_const, k_lin, k_cap, k_init, k_gain, k_hours, k_res;
   bit     k_allow;
   longint s_net, s_dis, s_chg, s_cur, s_q, s_vprev;
   tick_word_type pending_ticks[$];
   int  errors = 0;
   int  cycles = 0;
   int  hold_cycles = 0;
   bit  rx_random = 1;

   function automatic longint clampl(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b) / ONE;
   endfunction

   function automatic void predict_tick(longint p, bit last);
      longint v, iraw, q, cap, ratio, loss, et, cpow, dpow;
      tick_word_type w;
      if (p >= 0 || k_allow) s_net = clampl(s_net + p, S40_MIN, S40_MAX);
      if (p >= 0) s_dis = clampl(s_dis + p, 0, S40_MAX);
      if (k_allow && p < 0) s_chg = clampl(s_chg - p, 0, S40_MAX);
      if (!last) return;
      v = k_const + k_lin;
      if (s_vprev > v) v = s_vprev;
      iraw = 0;
      if (v > 0) iraw = clampl((s_net * ONE) / v, S32_MIN, S32_MAX);
      s_cur = clampl(s_cur + qmul(k_gain, iraw - s_cur), S32_MIN, S32_MAX);
      q = clampl(s_q - qmul(k_hours, s_cur), 0, U31_MAX);
      cap = k_cap > 0 ? k_cap : 1;
      loss = qmul(k_res, s_cur);
      ratio = clampl((q * ONE) / cap, 0, U31_MAX);
      et = k_const + qmul(k_lin, ONE - ratio) - loss;
      if (et > k_const) et = k_const;
      et = clampl(et, S32_MIN, S32_MAX);
      cpow = s_chg;
      dpow = s_dis;
      if (q <= 0) begin
         et = 0;
         if (dpow > cpow) dpow = cpow;
      end else if (q >= cap) begin
         q = cap;
         if (s_cur < 0) s_cur = 0;
         cpow = 0;
      end
      s_q = q;
      s_vprev = et;
      w.voltage = et[31:0];
      w.current = s_cur[31:0];
      w.charge  = q[30:0];
      w.status  = (q == cap) ? bcvs_pkg::STATUS_FULL :
                  (s_cur >= 0 ? bcvs_pkg::STATUS_DISCHARGING : bcvs_pkg::STATUS_CHARGING);
      w.chg_pwr = 31'(clampl(cpow, 0, U31_MAX));
      w.dis_pwr = 31'(clampl(dpow, 0, U31_MAX));
      pending_ticks.push_back(w);
      s_net = 0;
      s_dis = 0;
      s_chg = 0;
   endfunction

   task automatic write_reg(bcvs_pkg::csr_index_type idx, logic [31:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         bcvs_pkg::CSR_CONSTANT_COEF: begin
            k_const = longint'(signed'(val));
            s_vprev = k_const;
         end
         bcvs_pkg::CSR_LINEAR_COEF:    k_lin = longint'(signed'(val));
         bcvs_pkg::CSR_CAPACITY:       k_cap = val[30:0];
         bcvs_pkg::CSR_INITIAL_CHARGE: begin
            k_init = val[30:0];
            s_q = k_init;
         end
         bcvs_pkg::CSR_SMOOTHING_GAIN: k_gain = val[16:0];
         bcvs_pkg::CSR_STEP_HOURS:     k_hours = val[16:0];
         bcvs_pkg::CSR_RESISTANCE:     k_res = val[30:0];
         bcvs_pkg::CSR_ALLOW_CHARGING: k_allow = val[0];
         default: ;
      endcase
   endtask

   task automatic send_load(logic signed [31:0] p, bit last, bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 16) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1;
      req_load_power <= p;
      req_last_load  <= last;
      do @(posedge clock); while (req_stall);
      predict_tick(longint'(p), last);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic setup(longint c, longint l, longint cap, longint ic, longint g,
                        longint h, longint r, bit a);
      drain();
      write_reg(bcvs_pkg::CSR_CONSTANT_COEF, c[31:0]);
      write_reg(bcvs_pkg::CSR_LINEAR_COEF, l[31:0]);
      write_reg(bcvs_pkg::CSR_CAPACITY, cap[31:0]);
      write_reg(bcvs_pkg::CSR_INITIAL_CHARGE, ic[31:0]);
      write_reg(bcvs_pkg::CSR_SMOOTHING_GAIN, g[31:0]);
      write_reg(bcvs_pkg::CSR_STEP_HOURS, h[31:0]);
      write_reg(bcvs_pkg::CSR_RESISTANCE, r[31:0]);
      write_reg(bcvs_pkg::CSR_ALLOW_CHARGING, {31'b0, a});
      csr_write <= 0;
   endtask

   function automatic logic signed [31:0] rand_power();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 20) * 65536;
         2: return -$urandom_range(0, 20) * 65536;
         3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(0, 2000000)) - 1000000;
      endcase
   endfunction

   task automatic test_extremes();
      setup(12 * ONE, 3 * ONE, 2 * ONE, ONE, ONE, 0, 0, 1);
      send_load(32'sh7fffffff, 0);
      send_load(32'sh7fffffff, 0);
      send_load(32'sh80000000, 1);
      send_load(0, 1);
      send_load(-1, 0);
      send_load(1, 1);
      for (int i = 0; i < 300; i++) send_load(32'sh7fffffff, i == 299, 0);
   endtask

   task automatic test_charge_off();
      setup(12 * ONE, -4 * ONE, 10 * ONE, 5 * ONE, ONE / 2, ONE / 100, ONE / 20, 0);
      send_load(-5 * ONE, 0);
      send_load(3 * ONE, 1);
      send_load(-7 * ONE, 1);
   endtask

   task automatic test_empty_full();
      setup(12 * ONE, -2 * ONE, 2 * ONE, 10, ONE, ONE, ONE / 10, 1);
      send_load(50 * ONE, 0);
      send_load(-3 * ONE, 1);
      send_load(-60 * ONE, 1);
      setup(12 * ONE, 4 * ONE, 0, 0, 0, 65536, 0, 1);
      send_load(-ONE, 1);
      setup(-5 * ONE, 0, 1, 5 * ONE, ONE, 0, 32'h7fffffff, 1);
      send_load(10 * ONE, 1);
      setup(32'sh7fffffff, 32'sh80000000, 32'h7fffffff, 32'h7fffffff, ONE, ONE,
            ONE, 0);
      send_load(ONE, 1);
   endtask

   task automatic test_random();
      for (int s = 0; s < 7; s++) begin
         setup(longint'($urandom_range(0, 20)) * ONE - (s == 0 ? 30 * ONE : 0),
               longint'($signed($urandom_range(0, 16 * 65536))) - 8 * ONE,
               s == 1 ? 32'h7fffffff : $urandom_range(1, 20 * 65536),
               $urandom_range(0, 20 * 65536),
               s == 2 ? 0 : $urandom_range(0, 65536),
               s == 3 ? 65536 : $urandom_range(0, 2000),
               $urandom_range(0, 65536), $urandom_range(0, 1));
         for (int i = 0; i < 52; i++) send_load(rand_power(), $urandom_range(0, 2) == 0);
         send_load(rand_power(), 1);
      end
   endtask

   task automatic test_backpressure();
      setup(12 * ONE, 2 * ONE, 5 * ONE, 4 * ONE, ONE / 4, 100, ONE / 50, 1);
      rx_random = 0;
      hold_cycles = 600;
      for (int i = 0; i < 8; i++) send_load(rand_power(), 1, 0);
      rx_random = 1;
   endtask

   always @(posedge clock) begin
      tick_word_type w;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ticks.size() == 0) begin
            $error("result word with no expectation");
            errors++;
         end else begin
            w = pending_ticks.pop_front();
            if (rsp_terminal_voltage !== w.voltage) begin
               $error("terminal_voltage exp %0d got %0d", w.voltage, rsp_terminal_voltage);
               errors++;
            end
            if (rsp_current !== w.current) begin
               $error("current exp %0d got %0d", w.current, rsp_current);
               errors++;
            end
            if (rsp_charge !== w.charge) begin
               $error("charge exp %0d got %0d", w.charge, rsp_charge);
               errors++;
            end
            if (rsp_supply_status !== w.status) begin
               $error("supply_status exp %0d got %0d", w.status, rsp_supply_status);
               errors++;
            end
            if (rsp_charge_total !== w.chg_pwr) begin
               $error("charge_total exp %0d got %0d", w.chg_pwr, rsp_charge_total);
               errors++;
            end
            if (rsp_discharge_total !== w.dis_pwr) begin
               $error("discharge_total exp %0d got %0d", w.dis_pwr, rsp_discharge_total);
               errors++;
            end
         end
      end
   end

   initial begin : rx_stall_proc
      int n;
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_stall <= 0;
            @(posedge clock);
         end else if (rx_random && rsp_valid) begin
            n = $urandom_range(0, 16);
            if (n != 0) begin
               rsp_stall <= 1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 0;
            @(posedge clock);
         end else begin
            rsp_stall <= 0;
            @(posedge clock);
         end
      end
   end

   initial begin
      wait (cycles >= LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin
      k_const = 0; k_lin = 0; k_cap = ONE; k_init = ONE;
      k_gain = ONE; k_hours = 0; k_res = 0; k_allow = 0;
      s_net = 0; s_dis = 0; s_chg = 0; s_cur = 0; s_q = ONE; s_vprev = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_load(3 * ONE, 1);
      test_extremes();
      test_charge_off();
      test_empty_full();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

// File: sim.f
hdl/bcvs_pkg.sv
hdl/bcvs_div.sv
hdl/bcvs_datapath.sv
hdl/bcvs_ctrl.sv
hdl/battery_charge_voltage_step.sv
bench/testbench.sv
